@@ hw/rtl/keyframe_pose_interpolator_top_defines.svh @@
// Assertion macros used by the checker file.
`ifndef KEYFRAME_POSE_INTERPOLATOR_TOP_DEFINES_SVH
`define KEYFRAME_POSE_INTERPOLATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KPI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KPI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/kpi_pkg.sv @@
package kpi_pkg;

    localparam int VAL_W      = 32;
    localparam int POSE_VALS  = 6;
    localparam int LANE_W     = 3;
    localparam int FRAC_W     = 26;
    localparam int FRAC_LO_W  = 13;
    localparam int FC_W       = 18;
    localparam int DUR_W      = 10;
    localparam int STEP_W     = 16;
    localparam int PCNT_W     = 5;
    localparam int DIV_CNT_W  = 5;
    localparam int CFG_ADDR_W = 1;

    localparam logic [PCNT_W-1:0] PART_COUNT_RST = 5'd1;
    localparam logic [STEP_W-1:0] FRAME_STEP_RST = 16'd51;

    typedef enum logic [1:0] {
        FN_POSE = 2'd0,
        FN_DUR  = 2'd1,
        FN_HDR  = 2'd2,
        FN_TICK = 2'd3
    } t_func;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PART_COUNT = 1'b0,
        CFG_FRAME_STEP = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOT,
        S_DUR,
        S_DIV,
        S_RD,
        S_VAL
    } t_state;

    // One pose row: element 0 is pos x, element 5 is rot z.
    typedef logic [POSE_VALS-1:0][VAL_W-1:0] t_pose_row;

    typedef struct packed {
        logic              vld;
        logic [LANE_W-1:0] lane;
        logic [VAL_W-1:0]  v0;
        logic [VAL_W-1:0]  v1;
    } t_lerp_in;

    typedef struct packed {
        logic              vld;
        logic [LANE_W-1:0] lane;
        logic [VAL_W-1:0]  value;
    } t_lerp_out;

endpackage

@@ hw/rtl/kpi_pose_mem.sv @@
module kpi_pose_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  kpi_pkg::t_pose_row  i_wdata,
    input  logic [AW-1:0]       i_raddr_a,
    input  logic [AW-1:0]       i_raddr_b,
    output kpi_pkg::t_pose_row  o_rdata_a,
    output kpi_pkg::t_pose_row  o_rdata_b
);

    kpi_pkg::t_pose_row r_mem [DEPTH];
    kpi_pkg::t_pose_row r_rd_a;
    kpi_pkg::t_pose_row r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

@@ hw/rtl/kpi_div.sv @@
module kpi_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [kpi_pkg::FRAC_W-1:0]  i_num,
    input  logic [kpi_pkg::DUR_W-1:0]   i_den,
    output logic                        o_done,
    output logic [kpi_pkg::FRAC_W-1:0]  o_quo
);

    logic                           r_busy;
    logic                           r_done;
    logic [kpi_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [kpi_pkg::DUR_W-1:0]      r_rem;
    logic [kpi_pkg::DUR_W-1:0]      r_den;
    logic [kpi_pkg::FRAC_W-1:0]     r_quo;
    logic [kpi_pkg::DUR_W:0]        trial;
    logic                           ge;

    // Restoring division, one quotient bit per cycle.
    assign trial = {r_rem, r_quo[kpi_pkg::FRAC_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == kpi_pkg::DIV_CNT_W'(kpi_pkg::FRAC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= ge ? kpi_pkg::DUR_W'(trial - {1'b0, r_den})
                        : trial[kpi_pkg::DUR_W-1:0];
            r_quo <= {r_quo[kpi_pkg::FRAC_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

@@ hw/rtl/kpi_lerp.sv @@
module kpi_lerp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kpi_pkg::t_lerp_in           i_in,
    input  logic [kpi_pkg::FRAC_W-1:0]  i_frac,
    output kpi_pkg::t_lerp_out          o_out
);

    localparam int DW = kpi_pkg::VAL_W + 1;
    localparam int MW = DW + kpi_pkg::FRAC_LO_W + 1;
    localparam int HI_W = kpi_pkg::FRAC_W - kpi_pkg::FRAC_LO_W;
    localparam int AW = 48;

    logic                          r_s1_vld;
    logic [kpi_pkg::LANE_W-1:0]    r_s1_lane;
    logic [kpi_pkg::VAL_W-1:0]     r_s1_v0;
    logic signed [DW-1:0]          r_s1_d;

    logic                          r_s2_vld;
    logic [kpi_pkg::LANE_W-1:0]    r_s2_lane;
    logic [kpi_pkg::VAL_W-1:0]     r_s2_v0;
    logic signed [DW-1:0]          r_s2_d;
    logic signed [MW-1:0]          r_s2_plo;

    logic                          r_s3_vld;
    logic [kpi_pkg::LANE_W-1:0]    r_s3_lane;
    logic [kpi_pkg::VAL_W-1:0]     r_s3_v0;
    logic signed [MW-1:0]          r_s3_plo;
    logic signed [MW-1:0]          r_s3_phi;

    logic signed [kpi_pkg::FRAC_LO_W:0] frac_lo;
    logic signed [HI_W:0]               frac_hi;
    logic signed [DW-1:0]               diff;
    logic [AW-1:0]                      acc;

    assign frac_lo = {1'b0, i_frac[kpi_pkg::FRAC_LO_W-1:0]};
    assign frac_hi = {1'b0, i_frac[kpi_pkg::FRAC_W-1:kpi_pkg::FRAC_LO_W]};
    assign diff    = $signed({i_in.v1[kpi_pkg::VAL_W-1], i_in.v1})
                   - $signed({i_in.v0[kpi_pkg::VAL_W-1], i_in.v0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_in.vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_lane <= i_in.lane;
        r_s1_v0   <= i_in.v0;
        r_s1_d    <= diff;
        r_s2_lane <= r_s1_lane;
        r_s2_v0   <= r_s1_v0;
        r_s2_d    <= r_s1_d;
        r_s2_plo  <= MW'(r_s1_d * frac_lo);
        r_s3_lane <= r_s2_lane;
        r_s3_v0   <= r_s2_v0;
        r_s3_plo  <= r_s2_plo;
        r_s3_phi  <= MW'(r_s2_d * frac_hi);
    end

    // Only bits [47:16] of the rounded product matter, so sum modulo 2^48.
    assign acc = {r_s3_phi[AW-kpi_pkg::FRAC_LO_W-1:0], {kpi_pkg::FRAC_LO_W{1'b0}}}
               + AW'(r_s3_plo) + AW'(32768);

    always_comb begin
        o_out.vld   = r_s3_vld;
        o_out.lane  = r_s3_lane;
        o_out.value = r_s3_v0 + acc[AW-1:16];
    end

endmodule

@@ hw/rtl/keyframe_pose_interpolator_top.sv @@
// Channel   Direction  Handshake          Beat
// input     in         i_valid/o_ready    one load or tick item
// output    out        o_valid/i_ready    one interpolated part pose
// config    in         i_cfg_we           part_count, frame_step write
//
// Load items are written while idle and leave the engine idle. A tick is accepted, then
// fetches motion state and duration, runs the bit-serial fraction divider, then per
// part does one pose-memory read and six values go through the 3-stage interpolator.
// Reset is synchronous, active low; pose and duration memories are not cleared.
// An output stall holds the next part's memory read until the beat is taken.
module keyframe_pose_interpolator_top #(
    parameter int MAX_MOTIONS = 8,
    parameter int MAX_KEYS    = 16,
    parameter int PART_SLOTS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_func,
    input  logic [2:0]                        i_motion_id,
    input  logic [3:0]                        i_key_index,
    input  logic [3:0]                        i_part_index,
    input  logic signed [31:0]                i_pos_x_in,
    input  logic signed [31:0]                i_pos_y_in,
    input  logic signed [31:0]                i_pos_z_in,
    input  logic signed [31:0]                i_rot_x_in,
    input  logic signed [31:0]                i_rot_y_in,
    input  logic signed [31:0]                i_rot_z_in,
    input  logic [9:0]                        i_count_value,
    input  logic                              i_loop_flag,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [3:0]                        o_part_out,
    output logic signed [31:0]                o_pos_x_out,
    output logic signed [31:0]                o_pos_y_out,
    output logic signed [31:0]                o_pos_z_out,
    output logic signed [31:0]                o_rot_x_out,
    output logic signed [31:0]                o_rot_y_out,
    output logic signed [31:0]                o_rot_z_out,
    output logic                              o_last_part,
    output logic                              o_motion_end,
    input  logic                              i_cfg_we,
    input  logic [kpi_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [kpi_pkg::STEP_W-1:0]        i_cfg_data
);

    localparam int MW  = (MAX_MOTIONS > 1) ? $clog2(MAX_MOTIONS) : 1;
    localparam int KW  = $clog2(MAX_KEYS);
    localparam int KTW = $clog2(MAX_KEYS + 1);
    localparam int PW  = (PART_SLOTS > 1) ? $clog2(PART_SLOTS) : 1;
    localparam int PCW = $clog2(PART_SLOTS + 1);
    localparam int DAW = $clog2(MAX_MOTIONS * MAX_KEYS);
    localparam int PAW = $clog2(MAX_MOTIONS * MAX_KEYS * PART_SLOTS);
    localparam int FCW = kpi_pkg::FC_W;
    localparam int MSW = KTW + 1 + KW + FCW;
    localparam logic [MSW-1:0] MS_RST = {KTW'(1), 1'b0, KW'(0), FCW'(0)};
    localparam logic [kpi_pkg::LANE_W-1:0] LANE_END  = kpi_pkg::LANE_W'(kpi_pkg::POSE_VALS);
    localparam logic [kpi_pkg::LANE_W-1:0] LANE_LAST =
        kpi_pkg::LANE_W'(kpi_pkg::POSE_VALS - 1);

    kpi_pkg::t_state r_state, n_state;

    logic [kpi_pkg::PCNT_W-1:0] r_part_count;
    logic [kpi_pkg::STEP_W-1:0] r_frame_step;

    // motion state memory: {key total, loop, current key, frame counter}
    logic [MSW-1:0]         r_mmem [MAX_MOTIONS];
    logic [MAX_MOTIONS-1:0] r_mvld;
    logic [MSW-1:0]         r_mrd;
    logic                   r_mrd_vld;
    logic                   mm_we;
    logic [MW-1:0]          mm_waddr;
    logic [MSW-1:0]         mm_wdata;

    logic [kpi_pkg::DUR_W-1:0] r_dmem [MAX_MOTIONS * MAX_KEYS];
    logic [kpi_pkg::DUR_W-1:0] r_drd;
    logic                      dm_we;
    logic [DAW-1:0]            dm_waddr;
    logic [DAW-1:0]            dm_raddr;

    logic                pm_we;
    logic [PAW-1:0]      pm_waddr;
    logic [PAW-1:0]      pm_raddr_a;
    logic [PAW-1:0]      pm_raddr_b;
    kpi_pkg::t_pose_row  pm_wdata;
    kpi_pkg::t_pose_row  pm_rd_a;
    kpi_pkg::t_pose_row  pm_rd_b;

    logic                         div_start;
    logic                         div_done;
    logic [kpi_pkg::FRAC_W-1:0]   div_quo;

    kpi_pkg::t_lerp_in   lerp_in;
    kpi_pkg::t_lerp_out  lerp_out;

    logic [MW-1:0]               r_m, n_m;
    logic [KW-1:0]               r_cur, n_cur;
    logic [KW-1:0]               r_nxt, n_nxt;
    logic [KTW-1:0]              r_total, n_total;
    logic                        r_loop, n_loop;
    logic [FCW-1:0]              r_fc, n_fc;
    logic                        r_dur_zero, n_dur_zero;
    logic [kpi_pkg::FRAC_W-1:0]  r_frac, n_frac;
    logic                        r_ended, n_ended;
    logic [PW-1:0]               r_p, n_p;
    logic [PCW-1:0]              r_parts, n_parts;
    logic [kpi_pkg::LANE_W-1:0]  r_c, n_c;
    logic                        r_o_valid, n_o_valid;

    logic [PW-1:0]               r_o_part;
    logic                        r_o_last;
    logic                        r_o_end;
    logic [kpi_pkg::VAL_W-1:0]   r_o_pose [kpi_pkg::POSE_VALS];

    logic               acc_in;
    kpi_pkg::t_func     func;
    logic               m_ok, k_ok, p_ok;
    logic [MW-1:0]      m_idx;
    logic [KW-1:0]      k_idx;
    logic [PW-1:0]      p_idx;
    logic [KTW-1:0]     cnt_sat;

    logic [MSW-1:0]     md;
    logic [KTW-1:0]     md_total;
    logic               md_loop;
    logic [KW-1:0]      md_cur;
    logic [FCW-1:0]     md_fc;
    logic [KTW:0]       md_inc;
    logic [PCW-1:0]     parts_sat;
    logic               go;

    logic [FCW:0]       sum;
    logic [FCW:0]       thr;
    logic               adv;
    logic [KTW:0]       cur_inc;
    logic               has_next;
    logic               part_last;
    logic               lane_done;

    // ---------------- input decode ----------------
    assign acc_in  = i_valid && o_ready;
    assign func    = kpi_pkg::t_func'(i_func);
    assign m_ok    = int'(i_motion_id) < MAX_MOTIONS;
    assign k_ok    = int'(i_key_index) < MAX_KEYS;
    assign p_ok    = int'(i_part_index) < PART_SLOTS;
    assign m_idx   = MW'(i_motion_id);
    assign k_idx   = KW'(i_key_index);
    assign p_idx   = PW'(i_part_index);
    assign cnt_sat = (int'(i_count_value) > MAX_KEYS) ? KTW'(MAX_KEYS)
                                                      : KTW'(i_count_value);

    always_comb begin
        pm_wdata[0] = i_pos_x_in;
        pm_wdata[1] = i_pos_y_in;
        pm_wdata[2] = i_pos_z_in;
        pm_wdata[3] = i_rot_x_in;
        pm_wdata[4] = i_rot_y_in;
        pm_wdata[5] = i_rot_z_in;
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_count <= kpi_pkg::PART_COUNT_RST;
            r_frame_step <= kpi_pkg::FRAME_STEP_RST;
        end else if (i_cfg_we) begin
            case (kpi_pkg::t_cfg_reg'(i_cfg_addr))
                kpi_pkg::CFG_PART_COUNT: begin
                    r_part_count <= i_cfg_data[kpi_pkg::PCNT_W-1:0];
                end
                kpi_pkg::CFG_FRAME_STEP: begin
                    r_frame_step <= i_cfg_data;
                end
                default: begin
                    r_part_count <= r_part_count;
                end
            endcase
        end
    end

    // ---------------- motion state memory ----------------
    always_ff @(posedge i_clk) begin
        if (mm_we) begin
            r_mmem[mm_waddr] <= mm_wdata;
        end
        r_mrd <= r_mmem[m_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld    <= '0;
            r_mrd_vld <= 1'b0;
        end else begin
            r_mrd_vld <= r_mvld[m_idx];
            if (mm_we) begin
                r_mvld[mm_waddr] <= 1'b1;
            end
        end
    end

    // entry never written reads as its reset value
    assign md       = r_mrd_vld ? r_mrd : MS_RST;
    assign md_total = md[MSW-1 -: KTW];
    assign md_loop  = md[FCW + KW];
    assign md_cur   = md[FCW +: KW];
    assign md_fc    = md[FCW-1:0];
    assign md_inc   = (KTW+1)'(md_cur) + (KTW+1)'(1);
    assign parts_sat = (int'(r_part_count) > PART_SLOTS) ? PCW'(PART_SLOTS)
                                                         : PCW'(r_part_count);
    assign go = (md_total != '0) && ((KTW+1)'(md_cur) < (KTW+1)'(md_total))
             && (parts_sat != '0);

    // ---------------- key duration memory ----------------
    assign dm_raddr = DAW'(int'(r_m) * MAX_KEYS + int'(md_cur));

    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            r_dmem[dm_waddr] <= i_count_value;
        end
        r_drd <= r_dmem[dm_raddr];
    end

    // ---------------- pose memory ----------------
    assign pm_raddr_a = PAW'((int'(r_m) * MAX_KEYS + int'(r_cur)) * PART_SLOTS + int'(r_p));
    assign pm_raddr_b = PAW'((int'(r_m) * MAX_KEYS + int'(r_nxt)) * PART_SLOTS + int'(r_p));

    kpi_pose_mem #(
        .DEPTH (MAX_MOTIONS * MAX_KEYS * PART_SLOTS),
        .AW    (PAW)
    ) u_pose_mem (
        .i_clk     (i_clk),
        .i_we      (pm_we),
        .i_waddr   (pm_waddr),
        .i_wdata   (pm_wdata),
        .i_raddr_a (pm_raddr_a),
        .i_raddr_b (pm_raddr_b),
        .o_rdata_a (pm_rd_a),
        .o_rdata_b (pm_rd_b)
    );

    kpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({r_fc, 8'b0}),
        .i_den   (r_drd),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        lerp_in.vld  = (r_state == kpi_pkg::S_VAL) && (r_c != LANE_END);
        lerp_in.lane = r_c;
        lerp_in.v0   = pm_rd_a[r_c];
        lerp_in.v1   = pm_rd_b[r_c];
    end

    kpi_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (lerp_in),
        .i_frac  (r_frac),
        .o_out   (lerp_out)
    );

    // ---------------- counter advance ----------------
    assign sum      = (FCW+1)'(r_fc) + (FCW+1)'(r_frame_step);
    assign thr      = (FCW+1)'({r_drd, 8'b0});
    assign adv      = sum >= thr;
    assign cur_inc  = (KTW+1)'(r_cur) + (KTW+1)'(1);
    assign has_next = cur_inc < (KTW+1)'(r_total);

    assign part_last = (PCW'(r_p) + PCW'(1)) == r_parts;
    assign lane_done = lerp_out.vld && (lerp_out.lane == LANE_LAST);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            kpi_pkg::S_IDLE: begin
                if (acc_in && (func == kpi_pkg::FN_TICK) && m_ok) begin
                    n_state = kpi_pkg::S_MOT;
                end
            end
            kpi_pkg::S_MOT: begin
                n_state = go ? kpi_pkg::S_DUR : kpi_pkg::S_IDLE;
            end
            kpi_pkg::S_DUR: begin
                n_state = kpi_pkg::S_DIV;
            end
            kpi_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = kpi_pkg::S_RD;
                end
            end
            kpi_pkg::S_RD: begin
                if (!r_o_valid) begin
                    n_state = kpi_pkg::S_VAL;
                end
            end
            kpi_pkg::S_VAL: begin
                if (lane_done) begin
                    n_state = part_last ? kpi_pkg::S_IDLE : kpi_pkg::S_RD;
                end
            end
            default: begin
                n_state = kpi_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------- datapath control ----------------
    always_comb begin
        n_m        = r_m;
        n_cur      = r_cur;
        n_nxt      = r_nxt;
        n_total    = r_total;
        n_loop     = r_loop;
        n_fc       = r_fc;
        n_dur_zero = r_dur_zero;
        n_frac     = r_frac;
        n_ended    = r_ended;
        n_p        = r_p;
        n_parts    = r_parts;
        n_c        = r_c;
        n_o_valid  = r_o_valid;
        mm_we      = 1'b0;
        mm_waddr   = m_idx;
        mm_wdata   = {cnt_sat, i_loop_flag, KW'(0), FCW'(0)};
        dm_we      = 1'b0;
        dm_waddr   = DAW'(int'(m_idx) * MAX_KEYS + int'(k_idx));
        pm_we      = 1'b0;
        pm_waddr   = PAW'((int'(m_idx) * MAX_KEYS + int'(k_idx)) * PART_SLOTS + int'(p_idx));
        div_start  = 1'b0;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            kpi_pkg::S_IDLE: begin
                n_m = m_idx;
                if (acc_in && m_ok) begin
                    case (func)
                        kpi_pkg::FN_POSE: pm_we = k_ok && p_ok;
                        kpi_pkg::FN_DUR:  dm_we = k_ok;
                        kpi_pkg::FN_HDR:  mm_we = 1'b1;
                        default:          mm_we = 1'b0;
                    endcase
                end
            end
            kpi_pkg::S_MOT: begin
                n_cur   = md_cur;
                n_total = md_total;
                n_loop  = md_loop;
                n_fc    = md_fc;
                n_parts = parts_sat;
                n_nxt   = (md_inc >= (KTW+1)'(md_total)) ? KW'(0) : KW'(md_inc);
            end
            kpi_pkg::S_DUR: begin
                // write back the advanced counter now; the old values stay latched
                div_start  = 1'b1;
                n_dur_zero = (r_drd == '0);
                n_ended    = adv && !has_next && !r_loop;
                mm_we      = 1'b1;
                mm_waddr   = r_m;
                mm_wdata   = {r_total, r_loop,
                              (adv ? (has_next ? KW'(cur_inc) : KW'(0)) : r_cur),
                              (adv ? FCW'(0) : sum[FCW-1:0])};
            end
            kpi_pkg::S_DIV: begin
                n_p = '0;
                if (div_done) begin
                    n_frac = r_dur_zero ? '0 : div_quo;
                end
            end
            kpi_pkg::S_RD: begin
                n_c = '0;
            end
            kpi_pkg::S_VAL: begin
                if (lerp_in.vld) begin
                    n_c = r_c + 1'b1;
                end
                if (lane_done) begin
                    n_o_valid = 1'b1;
                    n_p       = r_p + 1'b1;
                end
            end
            default: begin
                n_c = r_c;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= kpi_pkg::S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m        <= n_m;
        r_cur      <= n_cur;
        r_nxt      <= n_nxt;
        r_total    <= n_total;
        r_loop     <= n_loop;
        r_fc       <= n_fc;
        r_dur_zero <= n_dur_zero;
        r_frac     <= n_frac;
        r_ended    <= n_ended;
        r_p        <= n_p;
        r_parts    <= n_parts;
        r_c        <= n_c;
        if (lerp_out.vld) begin
            r_o_pose[lerp_out.lane] <= lerp_out.value;
        end
        if (lane_done) begin
            r_o_part <= r_p;
            r_o_last <= part_last;
            r_o_end  <= r_ended;
        end
    end

    assign o_ready      = (r_state == kpi_pkg::S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_part_out   = 4'(r_o_part);
    assign o_pos_x_out  = r_o_pose[0];
    assign o_pos_y_out  = r_o_pose[1];
    assign o_pos_z_out  = r_o_pose[2];
    assign o_rot_x_out  = r_o_pose[3];
    assign o_rot_y_out  = r_o_pose[4];
    assign o_rot_z_out  = r_o_pose[5];
    assign o_last_part  = r_o_last;
    assign o_motion_end = r_o_end;

endmodule

@@ hw/rtl/kpi_checker.sv @@
`include "keyframe_pose_interpolator_top_defines.svh"

module kpi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [3:0]  o_part_out,
    input logic        o_last_part
);

    // hold a stalled beat
    `KPI_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_part_out), "output beat dropped or changed while stalled")

    // a pending part that is not the last keeps the engine busy
    `KPI_ASSERT_NOW(a_busy_mid_tick, o_valid && !o_last_part, !o_ready, "input taken while a tick is still emitting parts")

    // the next beat always needs a fresh memory read
    `KPI_ASSERT_NEXT(a_beat_gap, o_valid && i_ready, !o_valid, "output beat followed without a read bubble")

endmodule

bind keyframe_pose_interpolator_top kpi_checker u_kpi_checker (.*);
